FILE: sv/spm_pkg.sv
// spm_pkg: shared types, constants and field layout for the sprite pixel priority mux.
// No dependencies; used by spm_slot_bank, spm_prio and sprite_pixel_priority_mux.
`timescale 1ns / 1ps

package spm_pkg;

	localparam int SLOT_COUNT = 8;

	localparam int SLOT_W    = 3;
	localparam int PAT_W     = 8;
	localparam int POS_W     = 8;
	localparam int PAL_W     = 2;
	localparam int PIX_W     = 2;
	localparam int COLOR_W   = PAL_W + PIX_W;
	localparam int S_DATA_W  = 40;
	localparam int M_DATA_W  = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [POS_W-1:0] DOT_LAST = 8'd255;
	localparam logic [POS_W-1:0] DOT_MASK_END = 8'd8;

	// register index (paddr[2])
	localparam logic REG_SHOW_LEFT = 1'b0;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_DOT  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [SLOT_W-1:0]  slot;
		logic [PAT_W-1:0]   pattern_low;
		logic [PAT_W-1:0]   pattern_high;
		logic [POS_W-1:0]   sprite_x;
		logic [PAL_W-1:0]   palette_select;
		logic               behind_background;
		logic               is_sprite_zero;
		logic [POS_W-1:0]   dot_x;
		logic               bg_transparent;
	} item_t;

	// what one slot shows at the current dot
	typedef struct packed {
		logic               opaque;
		logic [PIX_W-1:0]   px;
		logic [PAL_W-1:0]   palette;
		logic               behind;
		logic               zero;
	} slot_tap_t;

	typedef struct packed {
		logic               sprite_drawn;
		logic [COLOR_W-1:0] color_slot;
		logic               zero_hit;
	} result_t;

endpackage

FILE: sv/spm_slot_bank.sv
// spm_slot_bank: per-slot sprite state (pattern shifters, X counters, attributes).
// Depends on spm_pkg. Loads a slot or shifts matching slots when upd is high.
`timescale 1ns / 1ps

module spm_slot_bank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  spm_pkg::item_t      item,
	input  logic                show_left,
	output spm_pkg::slot_tap_t  taps [spm_pkg::SLOT_COUNT]
);

	logic [spm_pkg::PAT_W-1:0] lo_q  [spm_pkg::SLOT_COUNT];
	logic [spm_pkg::PAT_W-1:0] hi_q  [spm_pkg::SLOT_COUNT];
	logic [spm_pkg::POS_W-1:0] pos_q [spm_pkg::SLOT_COUNT];
	logic [spm_pkg::PAL_W-1:0] pal_q [spm_pkg::SLOT_COUNT];
	logic                      beh_q [spm_pkg::SLOT_COUNT];
	logic                      zero_q[spm_pkg::SLOT_COUNT];

	logic is_dot;
	logic masked;

	assign is_dot = (item.cmd == spm_pkg::CMD_DOT);
	assign masked = (item.dot_x < spm_pkg::DOT_MASK_END) && !show_left;

	genvar i;
	generate
		for (i = 0; i < spm_pkg::SLOT_COUNT; i++) begin : g_slot
			logic active;
			logic wr_sel;
			logic [spm_pkg::PIX_W-1:0] px;

			// slot live at this dot: counter matches and pattern not exhausted
			assign active = is_dot && (pos_q[i] == item.dot_x) && ((lo_q[i] | hi_q[i]) != '0);
			assign wr_sel = (item.cmd == spm_pkg::CMD_LOAD) &&
				({{(32-spm_pkg::SLOT_W){1'b0}}, item.slot} == 32'(i));
			assign px = masked ? '0 : {hi_q[i][0], lo_q[i][0]};

			assign taps[i].opaque  = active && (px != '0);
			assign taps[i].px      = px;
			assign taps[i].palette = pal_q[i];
			assign taps[i].behind  = beh_q[i];
			assign taps[i].zero    = zero_q[i];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					lo_q[i]   <= '0;
					hi_q[i]   <= '0;
					pos_q[i]  <= '0;
					pal_q[i]  <= '0;
					beh_q[i]  <= 1'b0;
					zero_q[i] <= 1'b0;
				end else if (upd) begin
					if (wr_sel) begin
						lo_q[i]   <= item.pattern_low;
						hi_q[i]   <= item.pattern_high;
						pos_q[i]  <= item.sprite_x;
						pal_q[i]  <= item.palette_select;
						beh_q[i]  <= item.behind_background;
						zero_q[i] <= item.is_sprite_zero;
					end else if (active) begin
						lo_q[i]  <= lo_q[i] >> 1;
						hi_q[i]  <= hi_q[i] >> 1;
						pos_q[i] <= pos_q[i] + 1'b1;  // wraps at 255
					end
				end
			end
		end
	endgenerate

endmodule

FILE: sv/spm_prio.sv
// spm_prio: lowest-numbered opaque slot wins; front/behind decision and sprite-zero hit.
// Depends on spm_pkg. Pure combinational.
`timescale 1ns / 1ps

module spm_prio (
	input  spm_pkg::slot_tap_t taps [spm_pkg::SLOT_COUNT],
	input  logic [spm_pkg::POS_W-1:0] dot_x,
	input  logic               bg_transparent,
	output spm_pkg::result_t   res
);

	logic drawn;
	logic [spm_pkg::COLOR_W-1:0] color;
	logic hit;

	always_comb begin
		drawn = 1'b0;
		color = '0;
		hit   = 1'b0;
		// scan high to low so the lowest opaque slot lands last
		for (int k = spm_pkg::SLOT_COUNT - 1; k >= 0; k--) begin
			if (taps[k].opaque) begin
				drawn = !taps[k].behind || bg_transparent;
				color = drawn ? {taps[k].palette, taps[k].px} : '0;
			end
		end
		for (int k = 0; k < spm_pkg::SLOT_COUNT; k++) begin
			if (taps[k].opaque && taps[k].zero)
				hit = 1'b1;
		end
		hit = hit && !bg_transparent && (dot_x != spm_pkg::DOT_LAST);
	end

	assign res.sprite_drawn = drawn;
	assign res.color_slot   = color;
	assign res.zero_hit     = hit;

endmodule

FILE: sv/sprite_pixel_priority_mux.sv
// sprite_pixel_priority_mux: top level of the scanline sprite output stage.
// Depends on spm_pkg, spm_slot_bank, spm_prio.
`timescale 1ns / 1ps

// Channel   Dir  Signals                                   Contents
// s_*       in   s_tvalid s_tready s_tdata[39:0] s_tuser  load or dot beat
// m_*       out  m_tvalid m_tready m_tdata[7:0]           one result beat per input beat
// apb       in   psel penable pwrite paddr pready ...      show_left_sprites at 0x0
//
// One beat per clock sustained while m_tready stays high. A beat sits in the input stage
// (_s1) until the output register is free; the slot bank and priority logic read the slot
// state there. m_tvalid rises as the beat moves from _s1 into the output register. Slot
// state updates as the beat leaves _s1, so the next beat sees it. Reset clears all slots and
// the output valid flag. A stalled m_tready holds the output register; s_tready drops only
// when both stages hold beats and m_tready is low.

module sprite_pixel_priority_mux (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, low bit up: slot[2:0] pattern_low[10:3] pattern_high[18:11]
	// sprite_x[26:19] palette_select[28:27] behind_background[29]
	// is_sprite_zero[30] dot_x[38:31] bg_transparent[39]
	input  logic [spm_pkg::S_DATA_W-1:0]    s_tdata,
	// s_tuser: cmd[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, low bit up: sprite_drawn[0] color_slot[4:1] zero_hit[5] zero[7:6]
	output logic [spm_pkg::M_DATA_W-1:0]    m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [spm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [spm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	spm_pkg::item_t   item_in;
	spm_pkg::item_t   item_s1;
	logic             vld_s1;
	logic             adv;
	logic             accept;
	spm_pkg::result_t res_c;
	spm_pkg::result_t res_q;
	logic             out_vld_q;
	logic             show_left_q;
	spm_pkg::slot_tap_t taps [spm_pkg::SLOT_COUNT];

	// ---- config port ----
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_left_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == spm_pkg::REG_SHOW_LEFT)) begin
			show_left_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == spm_pkg::REG_SHOW_LEFT) ?
		{{(spm_pkg::APB_DATA_W-1){1'b0}}, show_left_q} : '0;

	// ---- input unpack ----
	assign item_in.cmd               = spm_pkg::cmd_t'(s_tuser);
	assign item_in.slot              = s_tdata[2:0];
	assign item_in.pattern_low       = s_tdata[10:3];
	assign item_in.pattern_high      = s_tdata[18:11];
	assign item_in.sprite_x          = s_tdata[26:19];
	assign item_in.palette_select    = s_tdata[28:27];
	assign item_in.behind_background = s_tdata[29];
	assign item_in.is_sprite_zero    = s_tdata[30];
	assign item_in.dot_x             = s_tdata[38:31];
	assign item_in.bg_transparent    = s_tdata[39];

	// ---- pipeline control ----
	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// ---- datapath ----
	spm_slot_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv),
		.item      (item_s1),
		.show_left (show_left_q),
		.taps      (taps)
	);

	spm_prio u_prio (
		.taps           (taps),
		.dot_x          (item_s1.dot_x),
		.bg_transparent (item_s1.bg_transparent),
		.res            (res_c)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, res_q.zero_hit, res_q.color_slot, res_q.sprite_drawn};

	// ---- assertions ----
	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && out_vld_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages full and output stalled");

	a_load_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.cmd == spm_pkg::CMD_LOAD) |=> (res_q == '0))
		else $error("load beat produced a nonzero result");

	a_drawn_opaque : assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && res_q.sprite_drawn) |-> (res_q.color_slot[1:0] != 2'b00))
		else $error("drawn pixel is transparent");

	a_no_hit_last : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.dot_x == spm_pkg::DOT_LAST) |=> !res_q.zero_hit)
		else $error("sprite-zero hit reported at last dot");

endmodule
